// ----- design/bats_pkg.sv -----
// Package for the band-averaged transmission scaler: table geometry, register
// indexes and the sequencer state type.
// Depends on nothing.
`default_nettype none

package bats_pkg;

	// table geometry
	localparam int TABLE_ROWS  = 256;
	localparam int NUM_TABLES  = 4;
	localparam int STORE_DEPTH = NUM_TABLES * TABLE_ROWS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SEG_W       = $clog2(TABLE_ROWS);
	localparam int CNT_W       = $clog2(TABLE_ROWS + 1);
	localparam int CMP_W       = (CNT_W > 9) ? CNT_W : 9;

	// configuration register indexes
	localparam logic [2:0] REG_BASE_FRACTION = 3'd0;
	localparam logic [2:0] REG_ROWS_FIRST    = 3'd1;
	localparam logic [2:0] REG_ROWS_LAST     = 3'd4;

	// item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// reset value of the base fraction, 1.0 in Q2.30
	localparam logic [31:0] BASE_RESET = 32'h4000_0000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TSEL,
		ST_P0,
		ST_SRD,
		ST_SCHK,
		ST_IA1,
		ST_IA2,
		ST_IA3,
		ST_IDIV,
		ST_SUM1,
		ST_SUM2,
		ST_NEXT,
		ST_AVG,
		ST_ADIV,
		ST_FM1,
		ST_FM2,
		ST_FM3,
		ST_RS1,
		ST_RS2,
		ST_EX1,
		ST_EX2
	} state_t;

endpackage

`default_nettype wire

// ----- design/band_averaged_transmission_scaler.sv -----
// Band-averaged transmission scaler: curve store, sequencer, shared 32x32
// multiplier and shared one-bit-per-cycle divider.
// Depends on bats_pkg.
`default_nettype none

// A load item (func 0) writes one curve row in the cycle it is accepted and
// keeps busy low. A query item (func 1) raises busy and walks every curve
// whose row count is nonzero; done pulses for one cycle with the result,
// which must be taken then, as the block cannot be held off. A query with no
// curve in use, or with an empty band, goes straight through RS1, RS2, EX1
// and EX2 and shows its result in the cycle after EX2. Otherwise the time
// is set by the 64-step divider, used twice per segment that overlaps the
// band and once per curve in use. The curve store has no reset and needs
// no clearing pass.
module band_averaged_transmission_scaler
	import bats_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [1:0]  table_sel,
	input  wire logic [7:0]  row_index,
	input  wire logic [31:0] row_energy,
	input  wire logic [16:0] row_trans,
	input  wire logic [31:0] band_low,
	input  wire logic [31:0] band_high,
	input  wire logic [31:0] resp_in,
	input  wire logic [47:0] expo_in,
	output logic             done,
	output logic [31:0]      band_factor,
	output logic [31:0]      resp_out,
	output logic [47:0]      expo_out,
	output logic             band_error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	state_t state_q, state_d;

	// configuration
	logic [31:0] base_q;
	logic [8:0]  rows_q [NUM_TABLES];

	// curve store: energy in the upper 32 bits, transmission below
	logic [48:0]       mem [STORE_DEPTH];
	logic [48:0]       rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;

	// query operands and walk state
	logic [31:0] lo_q, hi_q, resp_q;
	logic [47:0] expo_q;
	logic [31:0] factor_q;
	logic        err_q;
	logic [1:0]  tbl_q;
	logic [SEG_W-1:0] seg_q;
	logic [31:0] x0_q, x1_q, a_q, b_q;
	logic [16:0] y0_q, y1_q, ya_q;
	logic        pt_q;
	logic [63:0] sum_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_q, acc_q;

	// shared divider
	logic [63:0] quo_q, quo_next;
	logic [31:0] rem_q, rem_next, div_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_sh;
	logic        div_ge;

	// outputs
	logic        done_q;
	logic [31:0] band_factor_q, resp_out_q;
	logic [47:0] expo_out_q;
	logic        band_error_q;

	logic              accept;
	logic              used;
	logic [CMP_W-1:0]  n_eff;
	logic [31:0]       pnt;
	logic [31:0]       seg_d;
	logic [31:0]       band_w;
	logic [63:0]       fm_sum;
	logic [33:0]       fm_r;
	logic [63:0]       rs_sum;
	logic [95:0]       ex_sum;
	logic [49:0]       ex_r;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign used      = (rows_q[0] != '0) || (rows_q[1] != '0) ||
	                   (rows_q[2] != '0) || (rows_q[3] != '0);

	// rows in use for the current curve, capped at the table depth
	assign n_eff = (CMP_W'(rows_q[tbl_q]) > CMP_W'(TABLE_ROWS)) ?
	               CMP_W'(TABLE_ROWS) : CMP_W'(rows_q[tbl_q]);

	assign pnt    = pt_q ? b_q : a_q;
	assign seg_d  = x1_q - x0_q;
	assign band_w = hi_q - lo_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			for (int i = 0; i < NUM_TABLES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BASE_FRACTION) begin
				base_q <= cfg_data;
			end else if (cfg_index >= REG_ROWS_FIRST && cfg_index <= REG_ROWS_LAST) begin
				rows_q[2'(cfg_index - REG_ROWS_FIRST)] <= cfg_data[8:0];
			end
		end
	end

	// curve store ports
	assign wr_en   = accept && (func == FUNC_LOAD) && (32'(row_index) < TABLE_ROWS);
	assign wr_addr = ADDR_W'(ADDR_W'(table_sel) * ADDR_W'(TABLE_ROWS) + ADDR_W'(row_index));

	always_comb begin
		if (state_q == ST_SRD) begin
			rd_addr = ADDR_W'(ADDR_W'(tbl_q) * ADDR_W'(TABLE_ROWS) + ADDR_W'(seg_q) + 1'b1);
		end else begin
			rd_addr = ADDR_W'(ADDR_W'(tbl_q) * ADDR_W'(TABLE_ROWS));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {row_energy, row_trans};
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// multiplier operand selection
	always_comb begin
		unique case (state_q)
			ST_IA1: begin
				mul_a = x1_q - pnt;
				mul_b = 32'(y0_q);
			end
			ST_IA2: begin
				mul_a = pnt - x0_q;
				mul_b = 32'(y1_q);
			end
			ST_SUM1: begin
				mul_a = b_q - a_q;
				mul_b = 32'(ya_q) + 32'(quo_q[16:0]);
			end
			ST_FM1: begin
				mul_a = factor_q;
				mul_b = quo_q[31:0];
			end
			ST_FM2: begin
				mul_a = factor_q;
				mul_b = quo_q[63:32];
			end
			ST_RS1: begin
				mul_a = resp_q;
				mul_b = factor_q;
			end
			ST_RS2: begin
				mul_a = expo_q[31:0];
				mul_b = factor_q;
			end
			ST_EX1: begin
				mul_a = 32'(expo_q[47:32]);
				mul_b = factor_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// one restoring step of the divider
	assign rem_sh   = {rem_q, quo_q[63]};
	assign div_ge   = rem_sh >= {1'b0, div_q};
	assign rem_next = div_ge ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
	assign quo_next = {quo_q[62:0], div_ge};

	// rounding and saturation of the products
	assign fm_sum = acc_q + {mul_q[31:0], 32'd0} + 64'h2000_0000;
	assign fm_r   = fm_sum[63:30];
	assign rs_sum = mul_q + 64'h2000_0000;
	assign ex_sum = {32'd0, acc_q} + {mul_q, 32'd0} + 96'h2000_0000;
	assign ex_r   = ex_sum[79:30];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_QUERY) begin
					state_d = (used && band_high > band_low) ? ST_TSEL : ST_RS1;
				end
			end
			ST_TSEL: begin
				if (rows_q[tbl_q] == '0) begin
					state_d = (tbl_q == 2'd3) ? ST_RS1 : ST_TSEL;
				end else if (n_eff < CMP_W'(2)) begin
					state_d = ST_AVG;
				end else begin
					state_d = ST_P0;
				end
			end
			ST_P0:   state_d = ST_SRD;
			ST_SRD:  state_d = ST_SCHK;
			ST_SCHK: begin
				if (hi_q <= x0_q) begin
					state_d = ST_AVG;
				end else if (rd_data_q[48:17] <= lo_q || rd_data_q[48:17] <= x0_q) begin
					state_d = ST_NEXT;
				end else begin
					state_d = ST_IA1;
				end
			end
			ST_IA1:  state_d = ST_IA2;
			ST_IA2:  state_d = ST_IA3;
			ST_IA3:  state_d = ST_IDIV;
			ST_IDIV: begin
				if (cnt_q == '0) begin
					state_d = pt_q ? ST_SUM1 : ST_IA1;
				end
			end
			ST_SUM1: state_d = ST_SUM2;
			ST_SUM2: state_d = ST_NEXT;
			ST_NEXT: begin
				state_d = (CMP_W'(seg_q) + CMP_W'(2) < n_eff) ? ST_SRD : ST_AVG;
			end
			ST_AVG:  state_d = ST_ADIV;
			ST_ADIV: begin
				if (cnt_q == '0) begin
					state_d = ST_FM1;
				end
			end
			ST_FM1:  state_d = ST_FM2;
			ST_FM2:  state_d = ST_FM3;
			ST_FM3:  state_d = (tbl_q == 2'd3) ? ST_RS1 : ST_TSEL;
			ST_RS1:  state_d = ST_RS2;
			ST_RS2:  state_d = ST_EX1;
			ST_EX1:  state_d = ST_EX2;
			ST_EX2:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EX2);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		unique case (state_q)
			ST_IDLE: begin
				lo_q     <= band_low;
				hi_q     <= band_high;
				resp_q   <= resp_in;
				expo_q   <= expo_in;
				tbl_q    <= '0;
				err_q    <= used && band_high <= band_low;
				factor_q <= (used && band_high <= band_low) ? 32'd0 : base_q;
			end
			ST_TSEL: begin
				sum_q <= '0;
				seg_q <= '0;
				if (rows_q[tbl_q] == '0) begin
					tbl_q <= tbl_q + 2'd1;
				end
			end
			ST_P0: begin
				x0_q <= rd_data_q[48:17];
				y0_q <= rd_data_q[16:0];
			end
			ST_SCHK: begin
				x1_q <= rd_data_q[48:17];
				y1_q <= rd_data_q[16:0];
				a_q  <= (x0_q < lo_q) ? lo_q : x0_q;
				b_q  <= (hi_q < rd_data_q[48:17]) ? hi_q : rd_data_q[48:17];
				pt_q <= 1'b0;
			end
			ST_IA2: begin
				acc_q <= mul_q;
			end
			ST_IA3: begin
				quo_q <= acc_q + mul_q + 64'(seg_d >> 1);
				rem_q <= '0;
				div_q <= seg_d;
				cnt_q <= '1;
			end
			ST_IDIV, ST_ADIV: begin
				quo_q <= quo_next;
				rem_q <= rem_next;
				cnt_q <= cnt_q - 6'd1;
				if (state_q == ST_IDIV && cnt_q == '0 && !pt_q) begin
					ya_q <= quo_next[16:0];
					pt_q <= 1'b1;
				end
			end
			ST_SUM2: begin
				sum_q <= sum_q + mul_q;
			end
			ST_NEXT: begin
				x0_q  <= x1_q;
				y0_q  <= y1_q;
				seg_q <= seg_q + 1'b1;
			end
			ST_AVG: begin
				quo_q <= (sum_q << 13) + 64'(band_w >> 1);
				rem_q <= '0;
				div_q <= band_w;
				cnt_q <= '1;
			end
			ST_FM2: begin
				acc_q <= mul_q;
			end
			ST_FM3: begin
				factor_q <= (fm_r[33:32] != 2'b00) ? 32'hFFFF_FFFF : fm_r[31:0];
				tbl_q    <= tbl_q + 2'd1;
			end
			ST_RS2: begin
				resp_out_q <= (rs_sum[63:62] != 2'b00) ? 32'hFFFF_FFFF : rs_sum[61:30];
			end
			ST_EX1: begin
				acc_q <= mul_q;
			end
			ST_EX2: begin
				expo_out_q    <= (ex_r[49:48] != 2'b00) ? 48'hFFFF_FFFF_FFFF : ex_r[47:0];
				band_factor_q <= factor_q;
				band_error_q  <= err_q;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign band_factor = band_factor_q;
	assign resp_out    = resp_out_q;
	assign expo_out    = expo_out_q;
	assign band_error  = band_error_q;

`ifndef NO_ASSERTIONS
	// a result appears only once the query has left the sequencer
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an empty band with curves in use always gives a zero factor
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && band_error) |-> (band_factor == 32'd0))
		else $error("band error with nonzero factor");

	// the divider never runs on a zero divisor
	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDIV || state_q == ST_ADIV) |-> (div_q != 32'd0))
		else $error("division by zero");

	// a result comes in the cycle after the final expo step
	a_done_seq: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EX2))
		else $error("result strobe out of sequence");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for band_averaged_transmission_scaler: curve row loads,
// band queries and register writes, checked against an in-bench predictor.
// Depends on bats_pkg and the RTL of the block.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bats_pkg::*;

	localparam int     CYCLE_LIMIT  = 10_000_000;
	localparam int     RANDOM_ITEMS = 500;
	localparam int     SETTLE       = 20;
	localparam [63:0]  MASK32       = 64'hFFFF_FFFF;
	localparam [63:0]  MASK48       = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic        func;
		logic [1:0]  sel;
		logic [7:0]  row;
		logic [31:0] energy;
		logic [16:0] trans;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] resp;
		logic [47:0] expo;
	} item_t;

	typedef struct packed {
		logic [31:0] factor;
		logic [31:0] resp;
		logic [47:0] expo;
		logic        err;
	} result_t;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [2:0]  reg_idx;
		logic [31:0] reg_data;
		item_t       item;
		logic        typed;
		result_t     want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic func = FUNC_LOAD;
	logic [1:0] table_sel = '0;
	logic [7:0] row_index = '0;
	logic [31:0] row_energy = '0;
	logic [16:0] row_trans = '0;
	logic [31:0] band_low = '0;
	logic [31:0] band_high = '0;
	logic [31:0] resp_in = '0;
	logic [47:0] expo_in = '0;
	logic done;
	logic [31:0] band_factor;
	logic [31:0] resp_out;
	logic [47:0] expo_out;
	logic band_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	band_averaged_transmission_scaler dut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [31:0] curve_energy [STORE_DEPTH];
	logic [16:0] curve_trans [STORE_DEPTH];
	logic [8:0]  curve_rows [NUM_TABLES];
	logic [31:0] base_frac = BASE_RESET;

	result_t pending_results [$];
	int      failures = 0;
	int      cycles = 0;

	function automatic logic [63:0] interp_at(logic [63:0] x0, logic [63:0] x1,
			logic [63:0] y0, logic [63:0] y1, logic [63:0] p);
		logic [63:0] d;
		logic [63:0] num;
		d = x1 - x0;
		num = (x1 - p) * y0 + (p - x0) * y1;
		return (num + d / 2) / d;
	endfunction

	// twice the area under one curve over the band, trapezoids clipped to the band
	function automatic logic [63:0] curve_area(int t, logic [63:0] lo, logic [63:0] hi);
		int n;
		int k;
		logic [63:0] area, x0, x1, y0, y1, a, b;
		n = (curve_rows[t] > TABLE_ROWS) ? TABLE_ROWS : int'(curve_rows[t]);
		area = '0;
		for (int i = 0; i + 1 < n; i++) begin
			k = t * TABLE_ROWS + i;
			x0 = curve_energy[k];
			x1 = curve_energy[k + 1];
			y0 = curve_trans[k];
			y1 = curve_trans[k + 1];
			if (hi <= x0)
				break;
			if (x1 <= lo || x1 <= x0)
				continue;
			a = (x0 < lo) ? lo : x0;
			b = (hi < x1) ? hi : x1;
			area += (interp_at(x0, x1, y0, y1, a) + interp_at(x0, x1, y0, y1, b)) * (b - a);
		end
		return area;
	endfunction

	function automatic logic [31:0] scale_sat32(logic [63:0] v, logic [63:0] f);
		logic [63:0] r;
		r = (v * f + (64'd1 << 29)) >> 30;
		return (r > MASK32) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	function automatic logic [47:0] scale_sat48(logic [63:0] v, logic [63:0] f);
		logic [63:0] a, b, c, r;
		a = v * (f >> 16);
		b = v * (f & 64'hFFFF) + (64'd1 << 29);
		c = ((a & 64'h3FFF) << 16) + b;
		r = (a >> 14) + (c >> 30);
		return (r > MASK48) ? 48'hFFFF_FFFF_FFFF : r[47:0];
	endfunction

	function automatic result_t band_scaling(item_t it);
		result_t r;
		logic used;
		logic [63:0] factor, w, avg;
		used = 1'b0;
		for (int t = 0; t < NUM_TABLES; t++)
			if (curve_rows[t] != 0)
				used = 1'b1;
		factor = 64'(base_frac);
		r.err = 1'b0;
		if (used && it.hi <= it.lo) begin
			r.err = 1'b1;
			factor = '0;
		end else if (used) begin
			w = 64'(it.hi) - 64'(it.lo);
			for (int t = 0; t < NUM_TABLES; t++) begin
				if (curve_rows[t] != 0) begin
					avg = ((curve_area(t, it.lo, it.hi) << 13) + w / 2) / w;
					factor = 64'(scale_sat32(factor, avg));
				end
			end
		end
		r.factor = factor[31:0];
		r.resp = scale_sat32(64'(it.resp), factor);
		r.expo = scale_sat48(64'(it.expo), factor);
		return r;
	endfunction

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		got = '{band_factor, resp_out, expo_out, band_error};
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: factor %h resp %h expo %h err %b",
						got.factor, got.resp, got.expo, got.err);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					failures++;
					if (failures <= 10)
						$display("mismatch: factor %h/%h resp %h/%h expo %h/%h err %b/%b",
							want.factor, got.factor, want.resp, got.resp,
							want.expo, got.expo, want.err, got.err);
				end
			end
		end
	end

	// present one transaction and hold it until accepted; loads update the store
	task automatic issue(item_t it, logic typed, result_t want);
		func <= it.func;
		table_sel <= it.sel;
		row_index <= it.row;
		row_energy <= it.energy;
		row_trans <= it.trans;
		band_low <= it.lo;
		band_high <= it.hi;
		resp_in <= it.resp;
		expo_in <= it.expo;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (it.func == FUNC_LOAD) begin
			curve_energy[int'(it.sel) * TABLE_ROWS + int'(it.row)] = it.energy;
			curve_trans[int'(it.sel) * TABLE_ROWS + int'(it.row)] = it.trans;
		end else begin
			pending_results.push_back(typed ? want : band_scaling(it));
		end
	endtask

	// write a register once the block has drained
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_BASE_FRACTION)
			base_frac = data;
		else
			curve_rows[idx - REG_ROWS_FIRST] = data[8:0];
	endtask

	function automatic step_t load_row(logic [1:0] sel, logic [7:0] row,
			logic [31:0] e, logic [16:0] tr);
		step_t s;
		s = '0;
		s.kind = STEP_ITEM;
		s.item.func = FUNC_LOAD;
		s.item.sel = sel;
		s.item.row = row;
		s.item.energy = e;
		s.item.trans = tr;
		return s;
	endfunction

	function automatic step_t query_row(logic [31:0] lo, logic [31:0] hi,
			logic [31:0] resp, logic [47:0] expo);
		step_t s;
		s = '0;
		s.kind = STEP_ITEM;
		s.item.func = FUNC_QUERY;
		s.item.lo = lo;
		s.item.hi = hi;
		s.item.resp = resp;
		s.item.expo = expo;
		return s;
	endfunction

	function automatic step_t query_typed(logic [31:0] lo, logic [31:0] hi,
			logic [31:0] resp, logic [47:0] expo, result_t want);
		step_t s;
		s = query_row(lo, hi, resp, expo);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	function automatic step_t cfg_row(logic [2:0] idx, logic [31:0] data);
		step_t s;
		s = '0;
		s.kind = STEP_CFG;
		s.reg_idx = idx;
		s.reg_data = data;
		return s;
	endfunction

	// random query band within the loaded energy span, with some wild and empty bands
	function automatic item_t random_query(logic [31:0] span, logic narrow);
		item_t it;
		int pick;
		it = '0;
		it.func = FUNC_QUERY;
		it.resp = $urandom;
		it.expo = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			it.lo = $urandom;
			it.hi = $urandom;
		end else if (pick == 1) begin
			it.lo = $urandom_range(0, span);
			it.hi = it.lo - $urandom_range(0, 3);
		end else begin
			it.lo = $urandom_range(0, span);
			it.hi = it.lo + (narrow ? $urandom_range(1, 1 << 20) : $urandom_range(1, span));
		end
		return it;
	endfunction

	initial begin
		step_t plan [$];
		item_t it;
		result_t none;
		int sent;
		int phase;
		int n;
		int used;
		int burst;
		logic big;
		logic noisy;
		logic [31:0] e;
		logic [31:0] span;
		logic [8:0] rows_pick [NUM_TABLES];

		none = '0;
		for (int t = 0; t < NUM_TABLES; t++)
			curve_rows[t] = '0;

		// hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, extremes, empty bands, single row, flat segment
		plan = '{
			query_typed(32'd0, 32'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
				'{BASE_RESET, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0}),
			query_typed(32'd5, 32'd1, 32'd1234, 48'd5678,
				'{BASE_RESET, 32'd1234, 48'd5678, 1'b0}),
			load_row(2'd0, 8'd0, 32'h0000_0000, 17'h10000),
			load_row(2'd0, 8'd1, 32'h0001_0000, 17'h10000),
			load_row(2'd0, 8'd2, 32'h0002_0000, 17'h10000),
			load_row(2'd1, 8'd0, 32'hFFFF_FFFF, 17'h1FFFF),
			load_row(2'd2, 8'd0, 32'h0000_0000, 17'h00000),
			load_row(2'd2, 8'd1, 32'hFFFF_FFFF, 17'h10000),
			load_row(2'd3, 8'd0, 32'h0005_0000, 17'h00000),
			load_row(2'd3, 8'd1, 32'h0005_0000, 17'h1FFFF),
			cfg_row(REG_ROWS_FIRST, 32'd3),
			query_typed(32'h0, 32'h0002_0000, 32'h1234_5678, 48'h1234_5678_9ABC,
				'{BASE_RESET, 32'h1234_5678, 48'h1234_5678_9ABC, 1'b0}),
			query_typed(32'd7, 32'd7, 32'h1, 48'h1, '{32'h0, 32'h0, 48'h0, 1'b1}),
			query_typed(32'h0003_0000, 32'h0004_0000, 32'h55, 48'h66,
				'{32'h0, 32'h0, 48'h0, 1'b0}),
			query_row(32'h0000_8000, 32'h0001_8000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF),
			cfg_row(REG_ROWS_FIRST + 3'd1, 32'd1),
			query_typed(32'h0, 32'h0002_0000, 32'h5, 48'h5, '{32'h0, 32'h0, 48'h0, 1'b0}),
			cfg_row(REG_ROWS_FIRST + 3'd1, 32'd0),
			cfg_row(REG_ROWS_LAST, 32'd2),
			query_typed(32'h0, 32'h0006_0000, 32'h77, 48'h88, '{32'h0, 32'h0, 48'h0, 1'b0}),
			cfg_row(REG_ROWS_LAST, 32'd0),
			cfg_row(REG_ROWS_FIRST + 3'd2, 32'd2),
			cfg_row(REG_BASE_FRACTION, 32'hFFFF_FFFF),
			query_row(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF),
			load_row(2'd1, 8'd0, 32'h0000_0000, 17'h1FFFF),
			load_row(2'd1, 8'd1, 32'hFFFF_FFFF, 17'h1FFFF),
			cfg_row(REG_ROWS_FIRST + 3'd1, 32'd2),
			query_row(32'h0000_0100, 32'h7FFF_0000, 32'h8000_0000, 48'h8000_0000_0000),
			cfg_row(REG_BASE_FRACTION, 32'h0),
			query_typed(32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
				'{32'h0, 32'h0, 48'h0, 1'b0})
		};
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG)
				write_reg(plan[i].reg_idx, plan[i].reg_data);
			else
				issue(plan[i].item, plan[i].typed, plan[i].want);
		end

		// random phases: new settings, fresh curves, then mixed loads and queries
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			big = (phase == 3);
			for (int t = 0; t < NUM_TABLES; t++) begin
				n = $urandom_range(0, 9);
				rows_pick[t] = (n < 3) ? 9'd0 : (n == 3) ? 9'd1 : 9'($urandom_range(2, 6));
			end
			// one full curve, with a row count beyond the table depth
			if (big) begin
				rows_pick = '{9'd511, 9'd0, 9'd0, 9'd0};
			end
			if (phase == 1)
				write_reg(REG_BASE_FRACTION, 32'h0);
			else if (phase == 2)
				write_reg(REG_BASE_FRACTION, 32'hFFFF_FFFF);
			else if ($urandom_range(0, 1))
				write_reg(REG_BASE_FRACTION, $urandom);
			else
				write_reg(REG_BASE_FRACTION, $urandom_range(32'h2000_0000, 32'h6000_0000));
			for (int t = 0; t < NUM_TABLES; t++)
				write_reg(REG_ROWS_FIRST + 3'(t), {23'($urandom), rows_pick[t]});

			// reload every row that a query of this phase will read
			span = 32'h10_0000;
			for (int t = 0; t < NUM_TABLES; t++) begin
				used = (rows_pick[t] > TABLE_ROWS) ? TABLE_ROWS : int'(rows_pick[t]);
				noisy = ($urandom_range(0, 9) == 0);
				e = $urandom_range(0, 1 << 20);
				for (int i = 0; i < used; i++) begin
					it = '0;
					it.func = FUNC_LOAD;
					it.sel = 2'(t);
					it.row = 8'(i);
					it.energy = noisy ? $urandom : e;
					it.trans = noisy ? 17'($urandom) : 17'($urandom_range(0, 65536));
					e += $urandom_range(0, 1 << 18);
					issue(it, 1'b0, none);
					sent++;
				end
				if (e > span)
					span = e;
			end

			n = big ? 3 : $urandom_range(4, 12);
			for (int j = 0; j < n; j++) begin
				if ($urandom_range(0, 3) == 0) begin
					it = '0;
					it.func = FUNC_LOAD;
					it.sel = 2'($urandom);
					it.row = 8'($urandom);
					it.energy = $urandom;
					it.trans = 17'($urandom);
				end else begin
					it = random_query(span, big);
				end
				issue(it, 1'b0, none);
				sent++;
				// drop start for a random burst, except near the end
				if (sent < RANDOM_ITEMS - 100 && $urandom_range(0, 2) == 0) begin
					burst = $urandom_range(1, 15);
					start <= 1'b0;
					repeat (burst) @(posedge clk);
				end
			end
			phase++;
		end

		// drain and settle
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
